// ===== rtl/core/esu_pkg.sv =====
// shared types and constants for the escape sequence unescaper
// no dependencies
`default_nettype none

package esu_pkg;

  // default depth of the run queue between decoder and serialiser
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned RUN_BYTES = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
    logic       error;
  } out_item_t;

  // all result bytes caused by one input item
  typedef struct packed {
    logic [RUN_BYTES-1:0][7:0] bytes;
    logic [1:0]                last_idx;
    logic                      str_last;
    logic                      err;
  } run_t;

  // head of the run queue as seen by the serialiser
  typedef struct packed {
    logic valid;
    run_t run;
  } q_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/esu_front.sv =====
// escape decoder: takes one item a cycle while accept_i is high, holds the
// escape state, bytes_mode register; at most one run per item; uses esu_pkg
`default_nettype none

module esu_front
  import esu_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_data_i,
  input  wire logic     accept_i,
  input  wire in_item_t in_item_i,
  output logic          run_push_o,
  output run_t          run_o
);

  typedef enum logic [2:0] {
    PH_PLAIN,
    PH_ESC,
    PH_HEX_FIRST,
    PH_HEX_RUN,
    PH_U4,
    PH_U8,
    PH_DISCARD
  } phase_e;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      cnt;
  } utf8_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [24:0] CP_MAX  = 25'h10FFFF;
  localparam logic [24:0] SURR_LO = 25'h00D800;
  localparam logic [24:0] SURR_HI = 25'h00DFFF;
  localparam logic [20:0] LIM1    = 21'h00007F;
  localparam logic [20:0] LIM2    = 21'h0007FF;
  localparam logic [20:0] LIM3    = 21'h00FFFF;
  localparam logic [7:0]  LEAD2   = 8'hC0;
  localparam logic [7:0]  LEAD3   = 8'hE0;
  localparam logic [7:0]  LEAD4   = 8'hF0;
  localparam logic [7:0]  CONT    = 8'h80;

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= LIM1) begin
      r.b[0] = cp[7:0];
      r.cnt  = 3'd1;
    end else if (cp <= LIM2) begin
      r.b[0] = LEAD2 | {3'b000, cp[10:6]};
      r.b[1] = CONT | {2'b00, cp[5:0]};
      r.cnt  = 3'd2;
    end else if (cp <= LIM3) begin
      r.b[0] = LEAD3 | {4'b0000, cp[15:12]};
      r.b[1] = CONT | {2'b00, cp[11:6]};
      r.b[2] = CONT | {2'b00, cp[5:0]};
      r.cnt  = 3'd3;
    end else begin
      r.b[0] = LEAD4 | {5'b00000, cp[20:18]};
      r.b[1] = CONT | {2'b00, cp[17:12]};
      r.b[2] = CONT | {2'b00, cp[11:6]};
      r.b[3] = CONT | {2'b00, cp[5:0]};
      r.cnt  = 3'd4;
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  digits_q, digits_d;
  logic [20:0] code_q, code_d;
  logic        above_q, above_d;
  logic        bytes_mode_q;

  logic [7:0]  ch;
  logic        last;
  logic        is_hex;
  logic [3:0]  dv;
  logic [7:0]  hex_next;
  logic        above_next;
  logic [7:0]  flush_src;
  logic        flush_above;
  logic [24:0] nv;
  logic [3:0]  need;
  utf8_t       fenc, uenc;

  logic            fault;
  logic            silent;
  logic [3:0][7:0] pb;
  logic [2:0]      n;
  logic [1:0]      n_m1;

  assign ch     = in_item_i.in_byte;
  assign last   = in_item_i.string_last;
  assign is_hex = (ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  // letters have bit 6 set and their low nibble is 1..6
  assign dv     = ch[6] ? (ch[3:0] + 4'd9) : ch[3:0];

  assign hex_next    = {code_q[3:0], dv};
  assign above_next  = above_q | (code_q[7:4] != 4'd0);
  // a run flushed by the final byte uses the value after that byte's digit
  assign flush_src   = is_hex ? hex_next : code_q[7:0];
  assign flush_above = is_hex ? above_next : above_q;
  assign nv          = {code_q, dv};
  assign need        = (phase_q == PH_U4) ? 4'd4 : 4'd8;
  assign fenc        = utf8_enc({13'd0, flush_src});
  assign uenc        = utf8_enc(nv[20:0]);

  always_comb begin
    phase_d  = phase_q;
    digits_d = digits_q;
    code_d   = code_q;
    above_d  = above_q;
    fault    = 1'b0;
    silent   = 1'b0;
    pb       = '0;
    n        = 3'd0;

    case (phase_q)
      PH_DISCARD: begin
        silent = 1'b1;
      end
      PH_ESC: begin
        phase_d = PH_PLAIN;
        case (ch)
          CH_N:      begin pb[0] = CH_LF;     n = 3'd1; end
          CH_R:      begin pb[0] = CH_CR;     n = 3'd1; end
          CH_T:      begin pb[0] = CH_TAB;    n = 3'd1; end
          CH_BSLASH: begin pb[0] = CH_BSLASH; n = 3'd1; end
          CH_SQUOTE: begin pb[0] = CH_SQUOTE; n = 3'd1; end
          CH_DQUOTE: begin pb[0] = CH_DQUOTE; n = 3'd1; end
          CH_LX, CH_UX: begin
            phase_d = PH_HEX_FIRST;
            code_d  = '0;
            above_d = 1'b0;
          end
          CH_LU: begin
            phase_d  = PH_U4;
            code_d   = '0;
            digits_d = '0;
          end
          CH_UU: begin
            phase_d  = PH_U8;
            code_d   = '0;
            digits_d = '0;
          end
          default: fault = 1'b1;
        endcase
      end
      PH_HEX_FIRST: begin
        if (!is_hex) begin
          fault = 1'b1;
        end else begin
          code_d  = {17'd0, dv};
          phase_d = PH_HEX_RUN;
        end
      end
      PH_HEX_RUN: begin
        if (is_hex) begin
          above_d = above_next;
          code_d  = {13'd0, hex_next};
        end else begin
          // the run goes out first, then the ending byte as a plain byte
          phase_d = PH_PLAIN;
          if (bytes_mode_q) begin
            pb[0] = code_q[7:0];
            n     = 3'd1;
          end else if (above_q) begin
            fault = 1'b1;
          end else begin
            pb = fenc.b;
            n  = fenc.cnt;
          end
          if (!fault) begin
            if (ch == CH_BSLASH) begin
              phase_d = PH_ESC;
            end else begin
              pb[n[1:0]] = ch;
              n          = n + 3'd1;
            end
          end
        end
      end
      PH_U4, PH_U8: begin
        if (!is_hex || nv > CP_MAX) begin
          fault = 1'b1;
        end else begin
          code_d   = nv[20:0];
          digits_d = digits_q + 4'd1;
          if (digits_d >= need) begin
            phase_d = PH_PLAIN;
            if (nv >= SURR_LO && nv <= SURR_HI) begin
              fault = 1'b1;
            end else begin
              pb = uenc.b;
              n  = uenc.cnt;
            end
          end
        end
      end
      default: begin
        phase_d = PH_PLAIN;
        if (ch == CH_BSLASH) begin
          phase_d = PH_ESC;
        end else begin
          pb[0] = ch;
          n     = 3'd1;
        end
      end
    endcase

    // end of string: an open hex run is flushed, any other open escape fails
    if (!silent && !fault && last) begin
      if (phase_d == PH_HEX_RUN) begin
        phase_d = PH_PLAIN;
        if (bytes_mode_q) begin
          pb[0] = flush_src;
          n     = 3'd1;
        end else if (flush_above) begin
          fault = 1'b1;
        end else begin
          pb = fenc.b;
          n  = fenc.cnt;
        end
      end else if (phase_d != PH_PLAIN) begin
        fault = 1'b1;
      end
    end

    if (fault || last) begin
      digits_d = '0;
      code_d   = '0;
      above_d  = 1'b0;
      phase_d  = (fault && !last) ? PH_DISCARD : PH_PLAIN;
    end
  end

  assign n_m1 = 2'(n - 3'd1);

  assign run_push_o     = accept_i && !silent && (fault || (n != 3'd0));
  assign run_o.bytes    = fault ? '0 : pb;
  assign run_o.last_idx = fault ? 2'd0 : n_m1;
  assign run_o.str_last = last;
  assign run_o.err      = fault;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_PLAIN;
      digits_q     <= '0;
      code_q       <= '0;
      above_q      <= 1'b0;
      bytes_mode_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bytes_mode_q <= cfg_data_i;
      end
      if (accept_i) begin
        phase_q  <= phase_d;
        digits_q <= digits_d;
        code_q   <= code_d;
        above_q  <= above_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esu_queue.sv =====
// short run queue between decoder and serialiser
// uses esu_pkg
`default_nettype none

module esu_queue
  import esu_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire run_t run_i,
  output logic      full_o,
  input  wire logic pop_i,
  output q_head_t   head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.run   = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esu_back.sv =====
// serialiser: walks the head run one byte a cycle into the output register
// while it is empty or being popped; uses esu_pkg
`default_nettype none

module esu_back
  import esu_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire q_head_t head_i,
  output logic         q_pop_o,
  output out_item_t    out_item_o,
  output logic         empty_o,
  input  wire logic    pop_i
);

  logic [1:0] idx_q;
  out_item_t  out_q;
  logic       valid_q;
  logic       load;
  logic       fin;

  assign load    = head_i.valid && (!valid_q || pop_i);
  assign fin     = (idx_q == head_i.run.last_idx);
  assign q_pop_o = load && fin;

  assign out_item_o = out_q;
  assign empty_o    = !valid_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte    <= head_i.run.bytes[idx_q];
      out_q.run_last    <= fin;
      out_q.string_done <= fin && head_i.run.str_last;
      out_q.error       <= head_i.run.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= fin ? 2'd0 : idx_q + 2'd1;
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/escape_sequence_unescaper_utf8.sv =====
// escape sequence unescaper, top level: decoder, run queue, serialiser
// an item's run is written to the run queue as the item is taken; the
// serialiser loads its bytes from the queue head into the output register
// throughput: one item a cycle in while not full, one result a cycle out
// when popped; QueueDepth run queue entries absorb up to four results each
// reset: asynchronous active low; plain copy, bytes_mode 0, queue empty
// uses esu_pkg, esu_front, esu_queue, esu_back
`default_nettype none

module escape_sequence_unescaper_utf8
  import esu_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  // configuration: bytes_mode
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire logic     cfg_data_i,
  // input item queue side
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t in_item_i,
  // result queue side
  output logic          empty,
  input  wire logic     pop,
  output out_item_t     out_item_o
);

  logic    accept;
  logic    run_push;
  run_t    run;
  q_head_t head;
  logic    q_pop;

  // the register write never has to wait
  assign cfg_ready_o = 1'b1;

  // an item is taken whenever the run queue has room; the decoder itself
  // never stalls, and items that give no result write nothing to the queue
  assign accept = push && !full;

  esu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .in_item_i  (in_item_i),
    .run_push_o (run_push),
    .run_o      (run)
  );

  // holds whole runs, so a multi-byte utf-8 sequence or a flushed hex run
  // followed by its ending byte never blocks the decoder side
  esu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (run_push),
    .run_i  (run),
    .full_o (full),
    .pop_i  (q_pop),
    .head_o (head)
  );

  // one byte of the head run per cycle into a registered output while it is
  // free or popped; the run leaves the queue as its last byte is loaded
  esu_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_pop_o    (q_pop),
    .out_item_o (out_item_o),
    .empty_o    (empty),
    .pop_i      (pop)
  );

endmodule

`default_nettype wire
